### rtl/c3f_pkg.sv
// Shared types, constants and a helper function of the 3x3 convolution filter.
package c3f_pkg;

  // Default largest image width.
  localparam int unsigned MaxWidthDef = 1024;
  // Bits of one colour channel, signed Q3.12.
  localparam int unsigned ChBits = 16;
  // Number of channels in one pixel.
  localparam int unsigned NumCh = 4;
  // Bits of one packed pixel.
  localparam int unsigned PixBits = ChBits * NumCh;
  // Bits of one signed Q7.8 coefficient.
  localparam int unsigned CoefBits = 16;
  // Bits of one packed kernel row.
  localparam int unsigned RowBits = 3 * CoefBits;
  // Bits of the norm scale, signed Q1.16.
  localparam int unsigned NormBits = 18;
  // Accumulator of nine tap products, kept exact.
  localparam int unsigned AccBits = 36;
  // Accumulator times scale.
  localparam int unsigned ProdBits = AccBits + NormBits;
  // Result after rounding shift.
  localparam int unsigned ShiftBits = 24;
  localparam int unsigned RndBits = ProdBits + 1 - ShiftBits;
  // Configuration port.
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = RowBits;
  localparam int unsigned WidthRegBits = 11;
  localparam int unsigned HeightBits = 16;

  // Register indexes.
  localparam logic [CfgIdxBits-1:0] RegCoefTop = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCoefMid = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegCoefBot = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegNorm    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegWidth   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegHeight  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegFiltA   = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegClip    = 3'd7;

  // Item modes.
  localparam logic ModePixel = 1'b0;
  localparam logic ModeFlush = 1'b1;

  // Q3.12 one.
  localparam logic signed [ChBits-1:0] QOne = 16'sd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] dy;
    logic [1:0] dx;
    logic       acc_clr;
    logic       mul;
    logic       load;
    logic       frame_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // Saturate a rounded result to the channel range, then clip to 0..1 if asked.
  function automatic logic [ChBits-1:0] finish_ch(input logic signed [RndBits-1:0] v,
                                                  input logic clip);
    logic signed [RndBits-1:0] hi;
    logic signed [RndBits-1:0] lo;
    logic signed [ChBits-1:0]  s;
    hi = RndBits'(32767);
    lo = -hi - RndBits'(1);
    if (v > hi) begin
      s = 16'sh7fff;
    end else if (v < lo) begin
      s = -16'sh7fff - 16'sd1;
    end else begin
      s = v[ChBits-1:0];
    end
    if (clip) begin
      if (s < 0) begin
        s = '0;
      end else if (s > QOne) begin
        s = QOne;
      end
    end
    return s;
  endfunction

endpackage

### rtl/c3f_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module c3f_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2052
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/c3f_ctrl.sv
// Controller: frame position counters, history pointers and the tap sequencer.
module c3f_ctrl #(
  parameter int unsigned MaxWidth = c3f_pkg::MaxWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   mode_i,
  output logic                                   in_stall_o,
  input  logic                                   restart_i,
  input  logic [$clog2(MaxWidth+1)-1:0]          w_eff_i,
  input  logic [c3f_pkg::HeightBits-1:0]         h_eff_i,
  input  c3f_pkg::status_t                       status_i,
  output c3f_pkg::cmd_t                          cmd_o,
  output logic [$clog2(2*MaxWidth+4)-1:0]        wr_addr_o,
  output logic [$clog2(2*MaxWidth+4)-1:0]        rd_addr_o
);

  localparam int unsigned Depth = 2 * MaxWidth + 4;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned SW = AW + 2;
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned NW = WW + 1;
  localparam int unsigned HB = c3f_pkg::HeightBits;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAP   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [1:0]    dy_q, dy_d, dx_q, dx_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HB-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] wptr_q, wptr_d, pptr_q, pptr_d;

  logic          accept;
  logic          in_done;
  logic          in_last_col;
  logic          out_last_col;
  logic          out_last_row;
  logic          last;
  logic [SW-1:0] addr_sum;

  assign accept       = in_valid_i && (state_q == S_IDLE);
  assign in_done      = in_row_q >= h_eff_i;
  assign in_last_col  = WW'(in_col_q) == (w_eff_i - WW'(1));
  assign out_last_col = WW'(out_col_q) == (w_eff_i - WW'(1));
  assign out_last_row = out_row_q == (h_eff_i - HB'(1));
  assign last         = out_last_col && out_last_row;
  assign in_stall_o   = state_q != S_IDLE;
  assign wr_addr_o    = wptr_q;

  // Tap address: centre pointer moved by a row and a column, clamped at the edges.
  always_comb begin
    addr_sum = SW'(pptr_q) + SW'(Depth);
    case (dy_q)
      2'd0: if (out_row_q != '0) addr_sum = addr_sum - SW'(w_eff_i);
      2'd2: if (!out_last_row) addr_sum = addr_sum + SW'(w_eff_i);
      default: ;
    endcase
    case (dx_q)
      2'd0: if (out_col_q != '0) addr_sum = addr_sum - SW'(1);
      2'd2: if (!out_last_col) addr_sum = addr_sum + SW'(1);
      default: ;
    endcase
    if (addr_sum >= SW'(2 * Depth)) begin
      addr_sum = addr_sum - SW'(2 * Depth);
    end else if (addr_sum >= SW'(Depth)) begin
      addr_sum = addr_sum - SW'(Depth);
    end
    rd_addr_o = addr_sum[AW-1:0];
  end

  // Next state, counters and commands.
  always_comb begin
    state_d   = state_q;
    dy_d      = dy_q;
    dx_d      = dx_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    cnt_d     = cnt_q;
    wptr_d    = wptr_q;
    pptr_d    = pptr_q;
    cmd_o     = '0;
    cmd_o.dy  = dy_q;
    cmd_o.dx  = dx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == c3f_pkg::ModeFlush) begin
            if (in_done) begin
              cmd_o.acc_clr = 1'b1;
              dy_d          = '0;
              dx_d          = '0;
              state_d       = S_TAP;
            end
          end else if (!in_done) begin
            // Store the pixel and step the input position.
            cmd_o.wr_en = 1'b1;
            wptr_d      = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
            cnt_d       = cnt_q + NW'(1);
            if (in_last_col) begin
              in_col_d = '0;
              in_row_d = in_row_q + HB'(1);
            end else begin
              in_col_d = in_col_q + CW'(1);
            end
            if (cnt_q >= NW'(w_eff_i) + NW'(1)) begin
              cmd_o.acc_clr = 1'b1;
              dy_d          = '0;
              dx_d          = '0;
              state_d       = S_TAP;
            end
          end
        end
      end
      S_TAP: begin
        // One history read per cycle over the nine taps.
        cmd_o.rd_en = 1'b1;
        if (dx_q == 2'd2) begin
          dx_d = '0;
          if (dy_q == 2'd2) begin
            state_d = S_DRAIN;
          end else begin
            dy_d = dy_q + 2'd1;
          end
        end else begin
          dx_d = dx_q + 2'd1;
        end
      end
      S_DRAIN: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.frame_end = last;
          state_d         = S_IDLE;
          if (last) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
            cnt_d     = '0;
            wptr_d    = '0;
            pptr_d    = '0;
          end else begin
            cnt_d  = cnt_q - NW'(1);
            pptr_d = (pptr_q == AW'(Depth - 1)) ? '0 : pptr_q + AW'(1);
            if (out_last_col) begin
              out_col_d = '0;
              out_row_d = out_row_q + HB'(1);
            end else begin
              out_col_d = out_col_q + CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A geometry write restarts the frame; the user must make it only while idle (not enforced here).
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      cnt_d     = '0;
      wptr_d    = '0;
      pptr_d    = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dy_q      <= '0;
      dx_q      <= '0;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cnt_q     <= '0;
      wptr_q    <= '0;
      pptr_q    <= '0;
    end else begin
      state_q   <= state_d;
      dy_q      <= dy_d;
      dx_q      <= dx_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      cnt_q     <= cnt_d;
      wptr_q    <= wptr_d;
      pptr_q    <= pptr_d;
    end
  end

endmodule

### rtl/c3f_datapath.sv
// Datapath: pixel history memory, per-channel multiply-accumulate, scaling and output register.
module c3f_datapath #(
  parameter int unsigned MaxWidth = c3f_pkg::MaxWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  c3f_pkg::cmd_t                         cmd_i,
  output c3f_pkg::status_t                      status_o,
  input  logic [$clog2(2*MaxWidth+4)-1:0]       wr_addr_i,
  input  logic [$clog2(2*MaxWidth+4)-1:0]       rd_addr_i,
  input  logic [c3f_pkg::PixBits-1:0]           pix_i,
  input  logic [c3f_pkg::RowBits-1:0]           coef_top_i,
  input  logic [c3f_pkg::RowBits-1:0]           coef_mid_i,
  input  logic [c3f_pkg::RowBits-1:0]           coef_bot_i,
  input  logic signed [c3f_pkg::NormBits-1:0]   norm_i,
  input  logic                                  filter_alpha_i,
  input  logic                                  clip_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [c3f_pkg::PixBits-1:0]           out_pix_o,
  output logic                                  frame_end_o
);

  localparam int unsigned Depth = 2 * MaxWidth + 4;
  localparam int unsigned CB = c3f_pkg::ChBits;
  localparam int unsigned NC = c3f_pkg::NumCh;

  logic [c3f_pkg::PixBits-1:0]          rdata;
  logic                                 rd_q;
  logic [1:0]                           dy_q, dx_q;
  logic [c3f_pkg::RowBits-1:0]          row_sel;
  logic signed [c3f_pkg::CoefBits-1:0]  coef;
  logic signed [2*CB-1:0]               tprod [NC];
  logic signed [c3f_pkg::AccBits-1:0]   acc_q [NC];
  logic signed [c3f_pkg::ProdBits-1:0]  prod_q [NC];
  logic signed [c3f_pkg::RndBits-1:0]   rnd [NC];
  logic [CB-1:0]                        calpha_q;
  logic                                 out_valid_q;
  logic [c3f_pkg::PixBits-1:0]          out_pix_q;
  logic                                 frame_end_q;

  c3f_ram #(
    .Width (c3f_pkg::PixBits),
    .Depth (Depth)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (pix_i),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (rdata)
  );

  // Coefficient of the tap whose data arrives this cycle.
  always_comb begin
    case (dy_q)
      2'd0:    row_sel = coef_top_i;
      2'd1:    row_sel = coef_mid_i;
      default: row_sel = coef_bot_i;
    endcase
    case (dx_q)
      2'd0:    coef = row_sel[31:16];
      2'd1:    coef = row_sel[15:0];
      default: coef = row_sel[47:32];
    endcase
    for (int ch = 0; ch < NC; ch++) begin
      tprod[ch] = coef * $signed(rdata[ch*CB +: CB]);
    end
  end

  // Rounding shift, ties toward plus infinity; unfiltered alpha takes the centre pixel's alpha.
  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      rnd[ch] = c3f_pkg::RndBits'((c3f_pkg::RndBits + c3f_pkg::ShiftBits)'(prod_q[ch])
                + ((c3f_pkg::RndBits + c3f_pkg::ShiftBits)'(1) <<< (c3f_pkg::ShiftBits - 1))
                >>> c3f_pkg::ShiftBits);
    end
    if (!filter_alpha_i) begin
      rnd[NC-1] = c3f_pkg::RndBits'($signed(calpha_q));
    end
  end

  // Tap pipeline, accumulators, scaling product, centre alpha and output register.
  always_ff @(posedge clk_i) begin
    dy_q <= cmd_i.dy;
    dx_q <= cmd_i.dx;
    for (int ch = 0; ch < NC; ch++) begin
      if (cmd_i.acc_clr) begin
        acc_q[ch] <= '0;
      end else if (rd_q) begin
        acc_q[ch] <= acc_q[ch] + c3f_pkg::AccBits'(tprod[ch]);
      end
      if (cmd_i.mul) begin
        prod_q[ch] <= c3f_pkg::ProdBits'(acc_q[ch]) * c3f_pkg::ProdBits'(norm_i);
      end
    end
    if (rd_q && dy_q == 2'd1 && dx_q == 2'd1) begin
      calpha_q <= rdata[NC*CB-1 -: CB];
    end
    if (cmd_i.load) begin
      for (int ch = 0; ch < NC; ch++) begin
        out_pix_q[ch*CB +: CB] <= c3f_pkg::finish_ch(rnd[ch], clip_i);
      end
      frame_end_q <= cmd_i.frame_end;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_pix_o         = out_pix_q;
  assign frame_end_o       = frame_end_q;

endmodule

### rtl/conv3x3_clamp_edge_filter.sv
// Top level of the 3x3 clamp-to-edge convolution filter: registers, controller and datapath.
// An item that only stores a pixel is taken without leaving idle; an item that yields a result
// steps through one write, nine history reads through the single read port, drain, scale, output.
// Results appear one row plus one pixel behind the input; flush items drain the rest.
// Reset (rst_ni low, asynchronous) clears the counters, state and output valid, and loads
// the identity kernel, unit scale, width 1024 and height 1; the history memory is not cleared.
module conv3x3_clamp_edge_filter #(
  parameter int unsigned MaxWidth = c3f_pkg::MaxWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [c3f_pkg::ChBits-1:0]   red_in_i,
  input  logic signed [c3f_pkg::ChBits-1:0]   green_in_i,
  input  logic signed [c3f_pkg::ChBits-1:0]   blue_in_i,
  input  logic signed [c3f_pkg::ChBits-1:0]   alpha_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [c3f_pkg::ChBits-1:0]   red_out_o,
  output logic signed [c3f_pkg::ChBits-1:0]   green_out_o,
  output logic signed [c3f_pkg::ChBits-1:0]   blue_out_o,
  output logic signed [c3f_pkg::ChBits-1:0]   alpha_out_o,
  output logic                                frame_end_o,
  input  logic                                cfg_we_i,
  input  logic [c3f_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [c3f_pkg::CfgDataBits-1:0]     cfg_data_i
);

  localparam int unsigned Depth = 2 * MaxWidth + 4;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned EW = (WW > c3f_pkg::WidthRegBits) ? WW : c3f_pkg::WidthRegBits;
  localparam int unsigned CB = c3f_pkg::ChBits;
  localparam int unsigned HB = c3f_pkg::HeightBits;

  logic [c3f_pkg::RowBits-1:0]        coef_top_q, coef_mid_q, coef_bot_q;
  logic signed [c3f_pkg::NormBits-1:0] norm_q;
  logic [c3f_pkg::WidthRegBits-1:0]   width_q;
  logic [HB-1:0]                      height_q;
  logic                               filt_a_q, clip_q;
  logic                               restart;
  logic [EW-1:0]                      width_ext;
  logic [WW-1:0]                      w_eff;
  logic [HB-1:0]                      h_eff;
  c3f_pkg::cmd_t                      cmd;
  c3f_pkg::status_t                   status;
  logic [AW-1:0]                      wr_addr, rd_addr;
  logic [c3f_pkg::PixBits-1:0]        pix_in, pix_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= '0;
      coef_mid_q <= c3f_pkg::RowBits'(256);
      coef_bot_q <= '0;
      norm_q     <= c3f_pkg::NormBits'(65536);
      width_q    <= c3f_pkg::WidthRegBits'(1024);
      height_q   <= HB'(1);
      filt_a_q   <= 1'b0;
      clip_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c3f_pkg::RegCoefTop: coef_top_q <= cfg_data_i;
        c3f_pkg::RegCoefMid: coef_mid_q <= cfg_data_i;
        c3f_pkg::RegCoefBot: coef_bot_q <= cfg_data_i;
        c3f_pkg::RegNorm:    norm_q     <= cfg_data_i[c3f_pkg::NormBits-1:0];
        c3f_pkg::RegWidth:   width_q    <= cfg_data_i[c3f_pkg::WidthRegBits-1:0];
        c3f_pkg::RegHeight:  height_q   <= cfg_data_i[HB-1:0];
        c3f_pkg::RegFiltA:   filt_a_q   <= cfg_data_i[0];
        c3f_pkg::RegClip:    clip_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   (cfg_idx_i == c3f_pkg::RegWidth || cfg_idx_i == c3f_pkg::RegHeight);

  // Effective geometry: zero acts as one, width limited to the line store.
  assign width_ext = EW'(width_q);
  always_comb begin
    if (width_ext == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > EW'(MaxWidth)) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = width_ext[WW-1:0];
    end
    h_eff = (height_q == '0) ? HB'(1) : height_q;
  end

  assign pix_in = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  c3f_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart),
    .w_eff_i    (w_eff),
    .h_eff_i    (h_eff),
    .status_i   (status),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  c3f_datapath #(
    .MaxWidth (MaxWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .wr_addr_i      (wr_addr),
    .rd_addr_i      (rd_addr),
    .pix_i          (pix_in),
    .coef_top_i     (coef_top_q),
    .coef_mid_i     (coef_mid_q),
    .coef_bot_i     (coef_bot_q),
    .norm_i         (norm_q),
    .filter_alpha_i (filt_a_q),
    .clip_i         (clip_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pix_o      (pix_out),
    .frame_end_o    (frame_end_o)
  );

  assign red_out_o   = pix_out[0*CB +: CB];
  assign green_out_o = pix_out[1*CB +: CB];
  assign blue_out_o  = pix_out[2*CB +: CB];
  assign alpha_out_o = pix_out[3*CB +: CB];

  // A result is never loaded over one that is still held by a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a stalled output");

  // The history is written only for an accepted pixel item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> (in_valid_i && !in_stall_o && mode_i == c3f_pkg::ModePixel))
    else $error("history written without an accepted pixel");

  // No input is taken while the tap sequencer reads the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> in_stall_o)
    else $error("input accepted during tap reads");

endmodule
